// ===== hw/rtl/seed_hit_diagonal_binner_top_assert.svh =====
// Assertion macros for the checker file of the seed-hit diagonal binner.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef SEED_HIT_DIAGONAL_BINNER_TOP_ASSERT_SVH
`define SEED_HIT_DIAGONAL_BINNER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("shd assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define SHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("shd assertion failed: next-cycle check");

`endif

// ===== hw/rtl/shd_pkg.sv =====
// Shared types and constants for the seed-hit diagonal binner.
// Depends on nothing; used by the front, queue, back and top modules.
package shd_pkg;

	// Default depth of the queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 4;

	// Register indexes of the configuration write channel.
	typedef enum logic [2:0] {
		CFG_BAND_WIDTH = 3'd0,
		CFG_MIN_SEEDS  = 3'd1,
		CFG_SPAN_LIMIT = 3'd2,
		CFG_SKIP_SELF  = 3'd3,
		CFG_SINGLE_ARC = 3'd4,
		CFG_QUERY_ID   = 3'd5
	} cfg_reg_t;

	// One closed or evaluated group of hits.
	typedef struct packed {
		logic [30:0] tgt;
		logic        rev;
		logic [30:0] lt;
		logic [30:0] lq;
		logic [30:0] ht;
		logic [30:0] hq;
		logic [30:0] cnt;
	} grp_t;

	// One queue word: the group closed by a hit, then the group ended by a final hit.
	typedef struct packed {
		logic a_vld;
		grp_t a;
		logic b_vld;
		grp_t b;
	} qent_t;

	// Filter settings seen by the back part.
	typedef struct packed {
		logic [30:0] band_width;
		logic [30:0] min_seeds;
		logic [30:0] span_limit;
		logic        skip_self;
		logic        single_arc;
		logic [30:0] query_id;
	} cfg_t;

endpackage

// ===== hw/rtl/shd_queue.sv =====
// Short FIFO of candidate-group words between the front and back parts.
// Depends on shd_pkg for the word type.
module shd_queue #(
	parameter int DEPTH = shd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  shd_pkg::qent_t wdata,
	output logic          full,
	input  logic          pop,
	output shd_pkg::qent_t rdata,
	output logic          nempty
);
	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	shd_pkg::qent_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign nempty  = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && nempty;
	assign rdata   = mem_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Store the pushed word
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/shd_front.sv =====
// Front part: accepts hits, tracks the open group and queues candidate groups.
// Depends on shd_pkg for the group and queue word types.
module shd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [30:0]    target_id,
	input  logic           target_rev,
	input  logic [30:0]    target_pos,
	input  logic [30:0]    query_pos,
	input  logic           final_hit,
	input  logic [30:0]    band_width,
	input  logic           q_full,
	output logic           push,
	output shd_pkg::qent_t push_ent
);
	logic               open_q;
	logic signed [31:0] first_q;
	shd_pkg::grp_t      grp_q;
	shd_pkg::grp_t      nxt;
	logic               acc;
	logic signed [31:0] diag;
	logic signed [32:0] dd;
	logic [32:0]        dd_abs;
	logic               far;
	logic               close;
	logic               start;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	// Classify the hit against the open group
	assign diag   = $signed({1'b0, target_pos}) - $signed({1'b0, query_pos});
	assign dd     = $signed({diag[31], diag}) - $signed({first_q[31], first_q});
	assign dd_abs = dd[32] ? (~dd + 33'd1) : dd;
	assign far    = dd_abs > {2'b00, band_width};
	assign close  = open_q && ((target_id != grp_q.tgt) || (target_rev != grp_q.rev) || far);
	assign start  = !open_q || close;

	// Fold the hit into the group it belongs to
	always_comb begin
		nxt = grp_q;
		if (start) begin
			nxt.tgt = target_id;
			nxt.rev = target_rev;
			nxt.lt  = target_pos;
			nxt.lq  = query_pos;
			nxt.ht  = target_pos;
			nxt.hq  = query_pos;
			nxt.cnt = 31'd1;
		end else begin
			if ({target_pos, query_pos} < {grp_q.lt, grp_q.lq}) begin
				nxt.lt = target_pos;
				nxt.lq = query_pos;
			end
			if ({target_pos, query_pos} > {grp_q.ht, grp_q.hq}) begin
				nxt.ht = target_pos;
				nxt.hq = query_pos;
			end
			if (grp_q.cnt != '1) begin
				nxt.cnt = grp_q.cnt + 31'd1;
			end
		end
	end

	// Queue the closed group and the group ended by a final hit
	assign push           = acc && (close || final_hit);
	assign push_ent.a_vld = close;
	assign push_ent.a     = grp_q;
	assign push_ent.b_vld = final_hit;
	assign push_ent.b     = nxt;

	// Hold group-open flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (acc) begin
			open_q <= !final_hit;
		end
	end

	// Hold group contents
	always_ff @(posedge clk) begin
		if (acc) begin
			grp_q <= nxt;
			if (start) begin
				first_q <= diag;
			end
		end
	end

endmodule

// ===== hw/rtl/shd_back.sv =====
// Back part: filters queued groups and presents anchors on the output word.
// Depends on shd_pkg for the group, queue word and filter settings types.
module shd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  shd_pkg::cfg_t  cfg,
	input  shd_pkg::qent_t head,
	input  logic           head_vld,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [30:0]    anchor_target,
	output logic           anchor_rev,
	output logic [30:0]    query_begin,
	output logic [30:0]    query_finish,
	output logic [30:0]    target_begin,
	output logic [30:0]    target_finish,
	output logic [30:0]    seed_total,
	output logic           run_end
);
	// Apply seed count, span and id filters to one group
	function automatic logic grp_pass(shd_pkg::grp_t g, shd_pkg::cfg_t c);
		logic signed [31:0] qspan;
		logic signed [31:0] tspan;
		logic signed [31:0] mspan;
		logic               ok;
		qspan = $signed({1'b0, g.hq}) - $signed({1'b0, g.lq});
		tspan = $signed({1'b0, g.ht}) - $signed({1'b0, g.lt});
		mspan = $signed({1'b0, c.span_limit});
		ok = (g.cnt >= c.min_seeds) && (qspan > mspan) && (tspan > mspan);
		if (c.skip_self && (g.tgt == c.query_id)) begin
			ok = 1'b0;
		end
		if (c.single_arc && !(g.tgt < c.query_id)) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	logic           vld_s1;
	logic           pa_s1;
	logic           pb_s1;
	shd_pkg::grp_t  a_s1;
	shd_pkg::grp_t  b_s1;
	logic           a_done_q;
	logic           out_vld_q;
	shd_pkg::grp_t  out_q;
	logic           out_end_q;
	logic           pa;
	logic           pb;
	logic           out_load;
	logic           use_b;
	logic           s1_free;
	logic           take;

	assign pa = head.a_vld && grp_pass(head.a, cfg);
	assign pb = head.b_vld && grp_pass(head.b, cfg);

	// Pick the next anchor out of the held stage
	assign use_b    = !pa_s1 || a_done_q;
	assign out_load = vld_s1 && (!out_vld_q || out_ready);
	assign s1_free  = out_load && (use_b || !pb_s1);
	assign take     = head_vld && (!vld_s1 || s1_free);
	assign pop      = take;

	// Advance the filter stage and the output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			a_done_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				vld_s1   <= pa || pb;
				a_done_q <= 1'b0;
			end else if (s1_free) begin
				vld_s1 <= 1'b0;
			end else if (out_load) begin
				a_done_q <= 1'b1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Hold payload of the filter stage and the output word
	always_ff @(posedge clk) begin
		if (take) begin
			pa_s1 <= pa;
			pb_s1 <= pb;
			a_s1  <= head.a;
			b_s1  <= head.b;
		end
		if (out_load) begin
			out_q     <= use_b ? b_s1 : a_s1;
			out_end_q <= use_b || !pb_s1;
		end
	end

	assign out_valid     = out_vld_q;
	assign anchor_target = out_q.tgt;
	assign anchor_rev    = out_q.rev;
	assign query_begin   = out_q.lq;
	assign query_finish  = out_q.hq;
	assign target_begin  = out_q.lt;
	assign target_finish = out_q.ht;
	assign seed_total    = out_q.cnt;
	assign run_end       = out_end_q;

endmodule

// ===== hw/rtl/seed_hit_diagonal_binner_top.sv =====
// Seed-hit diagonal binner: groups sorted seed hits into diagonal-band anchors.
// An anchor goes from the queue through the filter stage into the output register.
// Throughput: one hit per cycle while the queue is not full; the open-group compare runs
// against registered state. Two anchors of one hit go out in turn; the queue absorbs it.
// Reset: control registers take defaults, no group is open, queue and output are empty.
// Depends on shd_pkg, shd_front, shd_queue and shd_back.
module seed_hit_diagonal_binner_top #(
	parameter int QUEUE_DEPTH = shd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [30:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [30:0] target_id,
	input  logic        target_rev,
	input  logic [30:0] target_pos,
	input  logic [30:0] query_pos,
	input  logic        final_hit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] anchor_target,
	output logic        anchor_rev,
	output logic [30:0] query_begin,
	output logic [30:0] query_finish,
	output logic [30:0] target_begin,
	output logic [30:0] target_finish,
	output logic [30:0] seed_total,
	output logic        run_end
);
	localparam logic [30:0] BAND_WIDTH_RST = 31'd30;
	localparam logic [30:0] MIN_SEEDS_RST  = 31'd3;

	shd_pkg::cfg_t  cfg_q;
	logic           q_full;
	logic           push;
	shd_pkg::qent_t push_ent;
	logic           pop;
	shd_pkg::qent_t head;
	logic           head_vld;

	assign cfg_ready = 1'b1;

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_width <= BAND_WIDTH_RST;
			cfg_q.min_seeds  <= MIN_SEEDS_RST;
			cfg_q.span_limit <= '0;
			cfg_q.skip_self  <= 1'b0;
			cfg_q.single_arc <= 1'b0;
			cfg_q.query_id   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				shd_pkg::CFG_BAND_WIDTH: cfg_q.band_width <= cfg_data;
				shd_pkg::CFG_MIN_SEEDS:  cfg_q.min_seeds  <= cfg_data;
				shd_pkg::CFG_SPAN_LIMIT: cfg_q.span_limit <= cfg_data;
				shd_pkg::CFG_SKIP_SELF:  cfg_q.skip_self  <= cfg_data[0];
				shd_pkg::CFG_SINGLE_ARC: cfg_q.single_arc <= cfg_data[0];
				shd_pkg::CFG_QUERY_ID:   cfg_q.query_id   <= cfg_data;
				default: ;
			endcase
		end
	end

	shd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.target_id  (target_id),
		.target_rev (target_rev),
		.target_pos (target_pos),
		.query_pos  (query_pos),
		.final_hit  (final_hit),
		.band_width (cfg_q.band_width),
		.q_full     (q_full),
		.push       (push),
		.push_ent   (push_ent)
	);

	shd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_ent),
		.full   (q_full),
		.pop    (pop),
		.rdata  (head),
		.nempty (head_vld)
	);

	shd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.head          (head),
		.head_vld      (head_vld),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.anchor_target (anchor_target),
		.anchor_rev    (anchor_rev),
		.query_begin   (query_begin),
		.query_finish  (query_finish),
		.target_begin  (target_begin),
		.target_finish (target_finish),
		.seed_total    (seed_total),
		.run_end       (run_end)
	);

endmodule

// ===== hw/rtl/shd_checker.sv =====
// Port-level checks for the seed-hit diagonal binner, bound to the top level.
// Depends on seed_hit_diagonal_binner_top_assert.svh for the assertion macros.
`include "seed_hit_diagonal_binner_top_assert.svh"

module shd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [30:0] target_begin,
	input logic [30:0] target_finish,
	input logic [30:0] seed_total,
	input logic        run_end
);

	// A stalled output word stays valid
	`SHD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// A word that is not the last of its hit is followed at once by the next
	`SHD_ASSERT_NEXT(a_run_cont, clk, arst_n, out_valid && out_ready && !run_end, out_valid)
	// Every anchor carries at least one seed
	`SHD_ASSERT_NOW(a_seed_nz, clk, arst_n, out_valid, seed_total != 31'd0)
	// Emitted anchors have a strictly positive target span
	`SHD_ASSERT_NOW(a_tspan_pos, clk, arst_n, out_valid, target_finish > target_begin)

endmodule

bind seed_hit_diagonal_binner_top shd_checker u_shd_checker (.*);
